FILE: rtl/uerf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo range filter package
// Shared constants: default parameters, register map, reset values, limits.
// ----------------------------------------------------------------------------
package uerf_pkg;

    // default structural parameters
    localparam int WINDOW_DEPTH_DEF = 2;
    localparam int NUM_CHANNELS_DEF = 2;
    localparam int TICK_BITS_DEF    = 32;

    // field widths fixed by the interface
    localparam int TICK_W    = 32;
    localparam int DIST_Q4_W = 16;
    localparam int DIST_MM_W = 12;
    localparam int MAXD_W    = 12;
    localparam int SCALE_W   = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // register index (word address bit) codes
    localparam logic REG_MAX_DISTANCE = 1'b0;
    localparam logic REG_MM_PER_TICK  = 1'b1;

    // register reset values
    localparam logic [MAXD_W-1:0]  MAX_DISTANCE_RST = 12'd600;
    localparam logic [SCALE_W-1:0] MM_PER_TICK_RST  = 16'd11246;

    // raw distance clamp, 4000 mm in Q12.4
    localparam logic [DIST_Q4_W-1:0] RAW_MAX_Q4 = 16'd64000;

    // Q16 product to Q4: drop 12 bits, round half up
    localparam int RND_SHIFT = 12;

endpackage

FILE: rtl/ultrasonic_echo_range_filter_unit.sv
`timescale 1ns / 1ps
// Path: an edge beat is taken into the input register; a falling edge then loads the result register.
// Throughput: one edge beat per cycle; rising edges and out-of-range channels never stall.
// A falling edge waits in the input register only while the result register is still held.
// Reset: synchronous, active low; clears start times, windows, filtered values and both
// valid flags; the config registers return to 600 mm and 11246 (Q0.16).
// ----------------------------------------------------------------------------
// Ultrasonic echo range filter
// Echo pulse width to distance, outlier rejection, window minimum, smoothing.
// ----------------------------------------------------------------------------
module ultrasonic_echo_range_filter_unit #(
    parameter int WINDOW_DEPTH = uerf_pkg::WINDOW_DEPTH_DEF,
    parameter int NUM_CHANNELS = uerf_pkg::NUM_CHANNELS_DEF,
    parameter int TICK_BITS    = uerf_pkg::TICK_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    // edge event input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [uerf_pkg::TICK_W-1:0] s_tdata,   // [31:0] tick
    input  logic [1:0]                  s_tuser,   // [0] channel, [1] edge_level

    // filtered distance output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [15:0] distance_q4, [27:16] range_mm
    output logic                        m_tuser,   // [0] out_channel

    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uerf_pkg::APB_AW-1:0] paddr,
    input  logic [uerf_pkg::APB_DW-1:0] pwdata,
    output logic [uerf_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import uerf_pkg::*;

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PROD_W = TICK_BITS + SCALE_W;   // width x scale
    localparam int RND_W  = PROD_W + 1;            // plus rounding carry
    localparam int SHR_W  = RND_W - RND_SHIFT;     // after drop to Q4

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MAXD_W-1:0]  max_dist_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dist_reg <= MAX_DISTANCE_RST;
            scale_reg    <= MM_PER_TICK_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MAX_DISTANCE: max_dist_reg <= pwdata[MAXD_W-1:0];
                REG_MM_PER_TICK:  scale_reg    <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MAX_DISTANCE: prdata = {{(APB_DW-MAXD_W){1'b0}}, max_dist_reg};
            REG_MM_PER_TICK:  prdata = {{(APB_DW-SCALE_W){1'b0}}, scale_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register: holds one edge beat while the result side is busy
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic              in_channel_reg;
    logic              in_level_reg;
    logic [TICK_W-1:0] in_tick_reg;

    logic              ch_ok;
    logic              fall_item;
    logic              out_free;
    logic              advance;
    logic [CH_W-1:0]   ch_idx;

    // channels beyond NUM_CHANNELS are dropped silently
    assign ch_ok     = (32'(in_channel_reg) < NUM_CHANNELS);
    assign fall_item = !in_level_reg && ch_ok;
    assign ch_idx    = CH_W'(in_channel_reg);

    assign out_free  = !m_tvalid || m_tready;
    // only a falling edge needs the result register
    assign advance   = in_valid_reg && (!fall_item || out_free);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_channel_reg <= s_tuser[0];
            in_level_reg   <= s_tuser[1];
            in_tick_reg    <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Per-channel state
    // ------------------------------------------------------------------
    logic [TICK_BITS-1:0] start_reg  [NUM_CHANNELS];
    logic [DIST_Q4_W-1:0] filt_reg   [NUM_CHANNELS];
    logic [DIST_Q4_W-1:0] recent_reg [NUM_CHANNELS][WINDOW_DEPTH];

    // ------------------------------------------------------------------
    // Single-pass datapath
    // ------------------------------------------------------------------
    logic [TICK_BITS-1:0] pulse_width;
    logic [PROD_W-1:0]    product;
    logic [RND_W-1:0]     product_rnd;
    logic [SHR_W-1:0]     raw_shr;
    logic [DIST_Q4_W-1:0] raw_q4;
    logic [DIST_Q4_W-1:0] reading;
    logic [DIST_Q4_W-1:0] filt_old;
    logic [DIST_Q4_W-1:0] win_min;
    logic [DIST_Q4_W:0]   filt_sum;
    logic [DIST_Q4_W-1:0] filt_next;
    logic [DIST_Q4_W:0]   mm_sum;
    logic [DIST_MM_W-1:0] mm_next;

    // wrapped pulse width, modulo 2^TICK_BITS
    assign pulse_width = in_tick_reg[TICK_BITS-1:0] - start_reg[ch_idx];
    assign product     = PROD_W'(pulse_width) * PROD_W'(scale_reg);
    // Q16 -> Q4 with half-up rounding
    assign product_rnd = {1'b0, product} + RND_W'(1 << (RND_SHIFT - 1));
    assign raw_shr     = product_rnd[RND_W-1:RND_SHIFT];
    assign raw_q4      = (raw_shr > SHR_W'(RAW_MAX_Q4)) ? RAW_MAX_Q4
                                                        : raw_shr[DIST_Q4_W-1:0];

    assign filt_old = filt_reg[ch_idx];
    // outlier: fall back to the last filtered value
    assign reading  = (raw_q4 > {max_dist_reg, 4'b0000}) ? filt_old : raw_q4;

    // minimum over the window as it stands after the push
    always_comb begin
        win_min = reading;
        for (int i = 1; i < WINDOW_DEPTH; i++) begin
            if (recent_reg[ch_idx][i] < win_min) begin
                win_min = recent_reg[ch_idx][i];
            end
        end
    end

    assign filt_sum  = {1'b0, filt_old} + {1'b0, win_min} + (DIST_Q4_W+1)'(1);
    assign filt_next = filt_sum[DIST_Q4_W:1];
    assign mm_sum    = {1'b0, filt_next} + (DIST_Q4_W+1)'(8);
    assign mm_next   = mm_sum[DIST_MM_W+3:4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                start_reg[c] <= '0;
                filt_reg[c]  <= '0;
                for (int i = 0; i < WINDOW_DEPTH; i++) begin
                    recent_reg[c][i] <= '0;
                end
            end
        end else if (advance && ch_ok) begin
            if (in_level_reg) begin
                start_reg[ch_idx] <= in_tick_reg[TICK_BITS-1:0];
            end else begin
                for (int i = 0; i + 1 < WINDOW_DEPTH; i++) begin
                    recent_reg[ch_idx][i] <= recent_reg[ch_idx][i+1];
                end
                recent_reg[ch_idx][WINDOW_DEPTH-1] <= reading;
                filt_reg[ch_idx]                   <= filt_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                 m_valid_reg;
    logic                 m_channel_reg;
    logic [DIST_Q4_W-1:0] m_q4_reg;
    logic [DIST_MM_W-1:0] m_mm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg && fall_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && fall_item) begin
            m_channel_reg <= in_channel_reg;
            m_q4_reg      <= filt_next;
            m_mm_reg      <= mm_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_channel_reg;
    assign m_tdata  = {4'b0000, m_mm_reg, m_q4_reg};

`ifndef SYNTHESIS
    // a new result beat only follows a falling edge leaving the input register
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(advance && fall_item))
        else $error("result beat without a falling edge");

    // filtered distance never exceeds the 4000 mm clamp
    a_mm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[27:16] <= 12'd4000 && m_tdata[15:0] <= RAW_MAX_Q4))
        else $error("distance out of range");

    // back-pressure only with a beat held in the input register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && fall_item && m_tvalid && !m_tready))
        else $error("input stalled without cause");
`endif

endmodule
